@@ rtl/tphc_pkg.sv @@
`default_nettype none

package tphc_pkg;

  localparam int WordW   = 16;
  localparam int TdataW  = 112;

  typedef logic [WordW-1:0] word_t;
  typedef logic [3:0]       pos_t;
  typedef logic [1:0]       nbytes_t;

  // word position only matters up to the checksum field; saturate just past it
  localparam pos_t  CheckPos = 4'd8;
  localparam pos_t  PosSat   = 4'd9;

  localparam word_t HighByte = 16'hff00;
  localparam word_t AllOnes  = 16'hffff;

  localparam nbytes_t BytesNone = 2'd0;
  localparam nbytes_t BytesOne  = 2'd1;

  typedef struct packed {
    word_t   ph_sum;
    word_t   data;
    nbytes_t nbytes;
    logic    last;
  } item_t;

  function automatic word_t oc_add(input word_t a, input word_t b);
    logic [WordW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
  endfunction

  // ones'-complement sum of the six pseudo-header words
  function automatic word_t pseudo_sum(input logic [31:0] src, input logic [31:0] dst,
                                       input logic [7:0] proto, input word_t seglen);
    logic [18:0] t;
    logic [16:0] f;
    t = {3'b0, src[31:16]} + {3'b0, src[15:0]} + {3'b0, dst[31:16]}
      + {3'b0, dst[15:0]} + {11'b0, proto} + {3'b0, seglen};
    f = {1'b0, t[15:0]} + {14'b0, t[18:16]};
    return f[WordW-1:0] + {{(WordW-1){1'b0}}, f[WordW]};
  endfunction

endpackage

`default_nettype wire

@@ rtl/tphc_accum.sv @@
`default_nettype none

module tphc_accum import tphc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  advance,
  input  wire item_t item,
  input  wire logic  clear_csum,
  output word_t      checksum
);

  word_t running_sum;
  word_t running_sum_next;
  pos_t  word_pos;
  pos_t  word_pos_next;
  logic  inside_packet;
  word_t base;
  word_t addend;
  word_t inv;
  pos_t  cur_pos;

  always_comb begin
    base    = inside_packet ? running_sum : item.ph_sum;
    cur_pos = inside_packet ? word_pos : '0;
    case (item.nbytes)
      BytesNone: addend = '0;
      BytesOne:  addend = item.data & HighByte;
      default:   addend = item.data;
    endcase
    if (clear_csum && cur_pos == CheckPos) begin
      addend = '0;
    end
    running_sum_next = oc_add(base, addend);
    word_pos_next    = (cur_pos == PosSat) ? cur_pos : cur_pos + pos_t'(1);
    inv              = ~running_sum_next;
    checksum         = (inv == '0) ? AllOnes : inv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      word_pos      <= '0;
      inside_packet <= 1'b0;
    end else if (advance) begin
      running_sum   <= running_sum_next;
      word_pos      <= word_pos_next;
      inside_packet <= !item.last;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tcp_pseudo_header_checksum.sv @@
// TCP checksum over the IPv4 pseudo-header and a segment streamed as
// 16-bit words in network order.
// s_axis: one beat per segment word. The addresses, protocol and segment
//   length are taken from the first beat of a packet; tlast closes it.
// m_axis: one beat per packet, the finished checksum (never zero).
// cfg: single-bit write channel, clear_checksum_field (reset 1). When set,
//   segment word 8 is summed as zero. Always ready; write only when idle.
// The last word is registered, then its checksum in the output register.
// Throughput: one word per cycle unless stalled. The pseudo-header sum is
//   taken as a beat is registered; the running sum is one 16-bit end-around
//   add. Reset (rst, synchronous) clears the running sum and packet state
//   and drops any pending result; s_axis_tready is low during reset.
// When m_axis stalls, the result holds and words keep being summed;
//   s_axis_tready falls once a last word sits in the input register
//   waiting for the output register, and rises when the result is taken.
`default_nettype none

module tcp_pseudo_header_checksum import tphc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output      logic              s_axis_tready,
  // src_addr[31:0], dst_addr[63:32], protocol[71:64], segment_length[87:72],
  // data_word[103:88], word_bytes[105:104], zero fill[111:106]
  input  wire logic [TdataW-1:0] s_axis_tdata,
  input  wire logic              s_axis_tlast,
  output      logic              m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // checksum[15:0]
  output      logic [WordW-1:0]  m_axis_tdata,
  input  wire logic              cfg_valid,
  output      logic              cfg_ready,
  input  wire logic              cfg_data
);

  logic  a_valid;
  item_t a_item;
  logic  a_advance;
  logic  clear_csum;
  word_t checksum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_csum <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      clear_csum <= cfg_data;
    end
  end

  assign a_advance     = a_valid && (!a_item.last || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !rst && (!a_valid || a_advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_axis_tready) begin
      a_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      a_item.ph_sum <= pseudo_sum(s_axis_tdata[31:0], s_axis_tdata[63:32],
                                  s_axis_tdata[71:64], s_axis_tdata[87:72]);
      a_item.data   <= s_axis_tdata[103:88];
      a_item.nbytes <= s_axis_tdata[105:104];
      a_item.last   <= s_axis_tlast;
    end
  end

  tphc_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .advance    (a_advance),
    .item       (a_item),
    .clear_csum (clear_csum),
    .checksum   (checksum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (a_advance && a_item.last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_advance && a_item.last) begin
      m_axis_tdata <= checksum;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tphc_checker.sv @@
`default_nettype none

module tphc_checker import tphc_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              s_axis_tvalid,
  input wire logic              s_axis_tready,
  input wire logic              s_axis_tlast,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [WordW-1:0]  m_axis_tdata
);

  // stalled result holds
  a_m_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata != '0)
    else $error("checksum is zero");

  // a fresh result follows an accepted last beat on the input
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("result without a last beat");

  // input blocks only behind a stalled result
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

endmodule

bind tcp_pseudo_header_checksum tphc_checker u_tphc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
